>>> rtl/mlqs_pkg.sv
// Shared types and constants for the multilevel queue scheduler.
package mlqs_pkg;

    localparam int ARR_W   = 16;
    localparam int BUR_W   = 16;
    localparam int CLS_W   = 2;
    localparam int PID_W   = 7;
    localparam int TIME_W  = 23;

    // queue levels after class mapping
    localparam logic [1:0] LVL_SYS   = 2'd0;
    localparam logic [1:0] LVL_INT   = 2'd1;
    localparam logic [1:0] LVL_BATCH = 2'd2;
    localparam logic [1:0] LVL_NONE  = 2'd3;

    localparam logic [CLS_W-1:0] CLS_SYS   = 2'd1;
    localparam logic [CLS_W-1:0] CLS_BATCH = 2'd3;

    // one loaded process, as passed from the front end to the scheduler
    typedef struct packed {
        logic [ARR_W-1:0] arrival;
        logic [BUR_W-1:0] burst;
        logic [CLS_W-1:0] cls;
        logic             last;
    } mlqs_item_t;

    function automatic logic [1:0] level_of(input logic [CLS_W-1:0] c);
        logic [1:0] lv;
        lv = LVL_INT;
        if (c == CLS_SYS) lv = LVL_SYS;
        else if (c == CLS_BATCH) lv = LVL_BATCH;
        return lv;
    endfunction

endpackage

>>> rtl/mlqs_front.sv
// Input front end: takes process beats into a short two-entry queue.
module mlqs_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  mlqs_pkg::mlqs_item_t      in_item,
    output logic                      q_valid,
    input  logic                      q_ready,
    output mlqs_pkg::mlqs_item_t      q_item
);
    mlqs_pkg::mlqs_item_t buf_reg [2];
    logic       wp_reg, rp_reg, wp_next, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = buf_reg[rp_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) buf_reg[wp_reg] <= in_item;
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_full_noready: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !s_ready) else $error("ready while full");
    a_empty_novalid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !q_valid) else $error("valid while empty");
`endif
endmodule

>>> rtl/mlqs_sched.sv
// Scheduler back end: stores the batch and dispatches it by serial scans.
module mlqs_sched #(
    parameter int MAX_PROCS = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  mlqs_pkg::mlqs_item_t        q_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [mlqs_pkg::PID_W-1:0]  m_process_id,
    output logic [mlqs_pkg::TIME_W-1:0] m_start_time,
    output logic [mlqs_pkg::TIME_W-1:0] m_finish_time,
    output logic [mlqs_pkg::TIME_W-1:0] m_response_time,
    output logic [mlqs_pkg::TIME_W-1:0] m_turnaround_time,
    output logic [mlqs_pkg::TIME_W-1:0] m_waiting_time,
    output logic                        m_last_result
);
    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int TW    = mlqs_pkg::TIME_W;
    localparam int AW    = mlqs_pkg::ARR_W;
    localparam int BW    = mlqs_pkg::BUR_W;
    localparam int KEY_W = (AW > BW) ? AW : BW;

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_MIN   = 3'd1;  // earliest pending arrival scan
    localparam logic [2:0] ST_PICK  = 3'd2;  // ready winner scan
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_CLEAR = 3'd4;

    // process table memory, one read port (registered)
    mlqs_pkg::mlqs_item_t mem [MAX_PROCS];
    mlqs_pkg::mlqs_item_t rd_reg;
    logic [MAX_PROCS-1:0] done_reg;

    logic [2:0]       st_reg, st_next;
    logic [CNT_W-1:0] loaded_reg, disp_reg;
    logic [CNT_W-1:0] scan_reg;     // issue index
    logic             rv_reg;       // read data valid
    logic [IDX_W-1:0] ridx_reg;     // index of rd_reg
    logic [TW-1:0]    time_reg;
    logic             min_any_reg;
    logic [AW-1:0]    min_reg;
    logic             best_any_reg;
    logic [1:0]       best_lvl_reg;
    logic [KEY_W-1:0] best_key_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [AW-1:0]    best_arr_reg;
    logic [BW-1:0]    best_bur_reg;
    logic             outv_reg;

    logic             accept;
    logic [IDX_W-1:0] rd_addr;
    logic             issue;
    logic             pend;
    logic [1:0]       lv;
    logic [KEY_W-1:0] key;
    logic             better;
    logic [TW-1:0]    fin;

    assign accept  = q_valid && q_ready;
    assign q_ready = (st_reg == ST_LOAD);
    assign issue   = ((st_reg == ST_MIN) || (st_reg == ST_PICK))
                     && (scan_reg < loaded_reg);
    assign rd_addr = scan_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (accept && (loaded_reg < CNT_W'(MAX_PROCS)))
            mem[loaded_reg[IDX_W-1:0]] <= q_item;
        if (issue) rd_reg <= mem[rd_addr];
    end

    always_comb begin
        pend   = rv_reg && !done_reg[ridx_reg];
        lv     = mlqs_pkg::level_of(rd_reg.cls);
        key    = (lv == mlqs_pkg::LVL_BATCH) ? KEY_W'(rd_reg.arrival)
                                             : KEY_W'(rd_reg.burst);
        // scan runs in index order, so ties keep the earlier (lower) id
        better = !best_any_reg || (lv < best_lvl_reg)
                 || ((lv == best_lvl_reg) && (key < best_key_reg));
        fin    = time_reg + TW'(best_bur_reg);
    end

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_LOAD:  if (accept && q_item.last) st_next = ST_MIN;
            ST_MIN:   if (!issue && !rv_reg) st_next = ST_PICK;
            ST_PICK:  if (!issue && !rv_reg) begin
                st_next = best_any_reg ? ST_EMIT : ST_MIN;
            end
            ST_EMIT:  if (!outv_reg) st_next = ST_PICK;
            ST_CLEAR: st_next = ST_LOAD;
            default:  st_next = ST_LOAD;
        endcase
        if ((st_reg == ST_EMIT) && !outv_reg && ((disp_reg + CNT_W'(1)) == loaded_reg))
            st_next = ST_CLEAR;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_LOAD;
            loaded_reg   <= '0;
            disp_reg     <= '0;
            scan_reg     <= '0;
            rv_reg       <= 1'b0;
            done_reg     <= '0;
            time_reg     <= '0;
            min_any_reg  <= 1'b0;
            best_any_reg <= 1'b0;
            outv_reg     <= 1'b0;
        end else begin
            st_reg <= st_next;
            rv_reg <= issue;
            if (issue) scan_reg <= scan_reg + 1'b1;
            if (outv_reg && m_ready) outv_reg <= 1'b0;
            unique case (st_reg)
                ST_LOAD: begin
                    if (accept && (loaded_reg < CNT_W'(MAX_PROCS)))
                        loaded_reg <= loaded_reg + 1'b1;
                    scan_reg    <= '0;
                    min_any_reg <= 1'b0;
                end
                ST_MIN: begin
                    if (pend && (!min_any_reg || rd_reg.arrival < min_reg))
                        min_any_reg <= 1'b1;
                    if (!issue && !rv_reg) begin
                        // jump time to the earliest pending arrival
                        if (min_any_reg) time_reg <= TW'(min_reg);
                        scan_reg     <= '0;
                        best_any_reg <= 1'b0;
                    end
                end
                ST_PICK: begin
                    if (pend && (TW'(rd_reg.arrival) <= time_reg) && better)
                        best_any_reg <= 1'b1;
                    if (!issue && !rv_reg) begin
                        scan_reg    <= '0;
                        min_any_reg <= 1'b0;
                    end
                end
                ST_EMIT: begin
                    if (!outv_reg) begin
                        outv_reg              <= 1'b1;
                        done_reg[best_idx_reg] <= 1'b1;
                        disp_reg              <= disp_reg + 1'b1;
                        time_reg              <= fin;
                        scan_reg              <= '0;
                        best_any_reg          <= 1'b0;
                    end
                end
                ST_CLEAR: begin
                    // drop the batch; the final beat holds in the output registers
                    loaded_reg <= '0;
                    disp_reg   <= '0;
                    done_reg   <= '0;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        ridx_reg  <= rd_addr;
        if ((st_reg == ST_MIN) && pend && (!min_any_reg || rd_reg.arrival < min_reg))
            min_reg <= rd_reg.arrival;
        if ((st_reg == ST_PICK) && pend && (TW'(rd_reg.arrival) <= time_reg) && better) begin
            best_lvl_reg <= lv;
            best_key_reg <= key;
            best_idx_reg <= ridx_reg;
            best_arr_reg <= rd_reg.arrival;
            best_bur_reg <= rd_reg.burst;
        end
        if ((st_reg == ST_EMIT) && !outv_reg) begin
            m_process_id      <= mlqs_pkg::PID_W'(best_idx_reg) + 1'b1;
            m_start_time      <= time_reg;
            m_finish_time     <= fin;
            m_response_time   <= time_reg - TW'(best_arr_reg);
            m_turnaround_time <= fin - TW'(best_arr_reg);
            m_waiting_time    <= time_reg - TW'(best_arr_reg);
            m_last_result     <= (disp_reg + 1'b1) == loaded_reg;
        end
    end

    assign m_valid = outv_reg;

`ifndef ASSERT_OFF
    a_disp_le_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        disp_reg <= loaded_reg) else $error("dispatched exceeds loaded");
    a_load_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        loaded_reg <= CNT_W'(MAX_PROCS)) else $error("loaded count overflow");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != ST_LOAD) |-> !q_ready) else $error("accept while scheduling");
    a_emit_once: assert property (@(posedge aclk) disable iff (!aresetn)
        ((st_reg == ST_EMIT) && !outv_reg) |=> outv_reg) else $error("dispatch lost");
`endif
endmodule

>>> rtl/multilevel_queue_scheduler_core.sv
// Top level of the multilevel queue scheduler: front queue plus scheduler.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_valid/s_ready   | arrival, burst, class, last flag
//  m_      | out | m_valid/m_ready   | id, start, finish, response, turnaround, wait, last
//
// Loading takes one beat per cycle. After the last beat an arrival scan of the
// loaded table runs first. Each dispatch then costs one pick scan through the
// single table read port and one emit step; whenever no process is ready, an
// arrival scan and another pick scan follow. A clear state at the batch end
// drops the batch.
// Reset is synchronous, active low; the table needs no clearing.
// Stalls on m_ready hold the dispatch result; the front queue keeps taking
// up to two beats while the scheduler is busy.
module multilevel_queue_scheduler_core #(
    parameter int MAX_PROCS = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [15:0]                 s_arrival_time,
    input  logic [15:0]                 s_burst_time,
    input  logic [1:0]                  s_proc_class,
    input  logic                        s_last_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [6:0]                  m_process_id,
    output logic [22:0]                 m_start_time,
    output logic [22:0]                 m_finish_time,
    output logic [22:0]                 m_response_time,
    output logic [22:0]                 m_turnaround_time,
    output logic [22:0]                 m_waiting_time,
    output logic                        m_last_result
);
    mlqs_pkg::mlqs_item_t in_item, q_item;
    logic q_valid, q_ready;

    // pack the incoming beat
    assign in_item = '{arrival: s_arrival_time, burst: s_burst_time,
                       cls: s_proc_class, last: s_last_item};

    mlqs_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    mlqs_sched #(.MAX_PROCS(MAX_PROCS)) u_sched (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_process_id(m_process_id), .m_start_time(m_start_time),
        .m_finish_time(m_finish_time), .m_response_time(m_response_time),
        .m_turnaround_time(m_turnaround_time), .m_waiting_time(m_waiting_time),
        .m_last_result(m_last_result)
    );
endmodule

>>> tb/multilevel_queue_scheduler_core_test.sv
// Self-checking testbench for the multilevel queue scheduler core.
`timescale 1ns / 1ps

module multilevel_queue_scheduler_core_test;

    localparam int NPROC     = 64;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 300;

    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [1:0]  cls;
        logic        last;
    } proc_beat_t;

    typedef struct packed {
        logic [6:0]  pid;
        logic [22:0] start;
        logic [22:0] finish;
        logic [22:0] resp;
        logic [22:0] turn;
        logic [22:0] wait_t;
        logic        last;
    } dispatch_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [15:0] s_arrival_time = '0;
    logic [15:0] s_burst_time = '0;
    logic [1:0] s_proc_class = '0;
    logic s_last_item = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [6:0] m_process_id;
    logic [22:0] m_start_time, m_finish_time, m_response_time;
    logic [22:0] m_turnaround_time, m_waiting_time;
    logic m_last_result;

    multilevel_queue_scheduler_core #(.MAX_PROCS(NPROC)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_arrival_time(s_arrival_time), .s_burst_time(s_burst_time),
        .s_proc_class(s_proc_class), .s_last_item(s_last_item),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_process_id(m_process_id), .m_start_time(m_start_time),
        .m_finish_time(m_finish_time), .m_response_time(m_response_time),
        .m_turnaround_time(m_turnaround_time), .m_waiting_time(m_waiting_time),
        .m_last_result(m_last_result)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Predictor state: the batch table as loaded so far.
    logic [15:0] tbl_arr [NPROC];
    logic [15:0] tbl_bur [NPROC];
    logic [1:0]  tbl_cls [NPROC];
    bit          tbl_done [NPROC];
    int          tbl_count = 0;
    longint      sched_now = 0;

    proc_beat_t  pending_beats[$];
    dispatch_t   expected_dispatches[$];
    int          error_count = 0;

    // Idle knobs, percent: sender gap chance and receiver stall chance.
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_recv = 1'b0;
    bit          hold_send = 1'b0;

    function automatic int queue_level(logic [1:0] c);
        if (c == mlqs_pkg::CLS_SYS) return 0;
        if (c == mlqs_pkg::CLS_BATCH) return 2;
        return 1;
    endfunction

    // Run the non-preemptive multilevel schedule over the loaded table.
    task automatic schedule_batch();
        int total, issued, best, best_lv, lv;
        longint nxt, st, fin;
        dispatch_t d;
        total = tbl_count;
        issued = 0;
        nxt = 64'h7FFF_FFFF_FFFF;
        for (int i = 0; i < total; i++) if (tbl_arr[i] < nxt) nxt = tbl_arr[i];
        sched_now = nxt;
        while (issued < total) begin
            best = -1;
            best_lv = 3;
            for (int i = 0; i < total; i++) begin
                if (tbl_done[i] || tbl_arr[i] > sched_now) continue;
                lv = queue_level(tbl_cls[i]);
                if (best < 0 || lv < best_lv) begin
                    best = i; best_lv = lv;
                end else if (lv == best_lv) begin
                    if (lv == 2 ? tbl_arr[i] < tbl_arr[best] : tbl_bur[i] < tbl_bur[best]) begin
                        best = i;
                    end
                end
            end
            if (best < 0) begin
                nxt = 64'h7FFF_FFFF_FFFF;
                for (int i = 0; i < total; i++)
                    if (!tbl_done[i] && tbl_arr[i] < nxt) nxt = tbl_arr[i];
                sched_now = nxt;
                continue;
            end
            st = sched_now;
            fin = st + tbl_bur[best];
            sched_now = fin;
            tbl_done[best] = 1'b1;
            issued++;
            d.pid = 7'(best + 1);
            d.start = 23'(st);
            d.finish = 23'(fin);
            d.resp = 23'(st - tbl_arr[best]);
            d.turn = 23'(fin - tbl_arr[best]);
            d.wait_t = 23'(fin - tbl_arr[best] - tbl_bur[best]);
            d.last = (issued == total);
            expected_dispatches.push_back(d);
        end
        tbl_count = 0;
        for (int i = 0; i < NPROC; i++) tbl_done[i] = 1'b0;
    endtask

    // Store one accepted beat; a last beat triggers the schedule.
    task automatic load_beat(proc_beat_t b);
        if (tbl_count < NPROC) begin
            tbl_arr[tbl_count] = b.arrival;
            tbl_bur[tbl_count] = b.burst;
            tbl_cls[tbl_count] = b.cls;
            tbl_done[tbl_count] = 1'b0;
            tbl_count++;
        end
        if (b.last) schedule_batch();
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Driver: present the next pending beat, hold it until accepted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) load_beat({s_arrival_time, s_burst_time,
                                               s_proc_class, s_last_item});
            if (!s_valid || s_ready) begin
                if (pending_beats.size() > 0 && !hold_send &&
                    $urandom_range(99) >= send_idle_pct) begin
                    proc_beat_t b;
                    b = pending_beats.pop_front();
                    s_valid <= 1'b1;
                    s_arrival_time <= b.arrival;
                    s_burst_time <= b.burst;
                    s_proc_class <= b.cls;
                    s_last_item <= b.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result beat against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_dispatches.size() == 0) begin
                    report_mismatch("unexpected beat, id", m_process_id, 0);
                end else begin
                    dispatch_t e;
                    e = expected_dispatches.pop_front();
                    if (m_process_id !== e.pid) report_mismatch("id", m_process_id, e.pid);
                    if (m_start_time !== e.start)
                        report_mismatch("start", m_start_time, e.start);
                    if (m_finish_time !== e.finish)
                        report_mismatch("finish", m_finish_time, e.finish);
                    if (m_response_time !== e.resp)
                        report_mismatch("response", m_response_time, e.resp);
                    if (m_turnaround_time !== e.turn)
                        report_mismatch("turnaround", m_turnaround_time, e.turn);
                    if (m_waiting_time !== e.wait_t)
                        report_mismatch("waiting", m_waiting_time, e.wait_t);
                    if (m_last_result !== e.last)
                        report_mismatch("last", m_last_result, e.last);
                end
            end
            m_ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: count cycles with no beat on either channel.
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic proc_beat_t make_beat(int arr, int bur, int cls, bit last);
        proc_beat_t b;
        b.arrival = 16'(arr);
        b.burst = 16'(bur);
        b.cls = 2'(cls);
        b.last = last;
        return b;
    endfunction

    // Queue one random batch; small times keep processes contending.
    task automatic queue_random_batch(int n);
        int arr, bur;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) arr = $urandom_range(65535);
            else arr = $urandom_range(40);
            if ($urandom_range(9) == 0) bur = $urandom_range(65535);
            else bur = $urandom_range(12);
            pending_beats.push_back(make_beat(arr, bur, $urandom_range(3), i == n - 1));
        end
    endtask

    task automatic wait_drained();
        while (pending_beats.size() > 0 || s_valid || expected_dispatches.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        int phase_items;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, all classes including zero, ties, gaps.
        pending_beats.push_back(make_beat(0, 0, 1, 1'b1));
        pending_beats.push_back(make_beat(65535, 65535, 3, 1'b1));
        pending_beats.push_back(make_beat(5, 3, 2, 1'b0));
        pending_beats.push_back(make_beat(5, 3, 0, 1'b0));
        pending_beats.push_back(make_beat(0, 8, 3, 1'b0));
        pending_beats.push_back(make_beat(2, 1, 1, 1'b0));
        pending_beats.push_back(make_beat(2, 1, 1, 1'b0));
        pending_beats.push_back(make_beat(3, 2, 3, 1'b0));
        pending_beats.push_back(make_beat(1000, 4, 2, 1'b1));
        pending_beats.push_back(make_beat(43690, 21845, 1, 1'b0));
        pending_beats.push_back(make_beat(21845, 43690, 2, 1'b1));
        wait_drained();

        // Full table: 64 beats, then one more non-last dropped, then a last.
        for (int i = 0; i < NPROC; i++)
            pending_beats.push_back(make_beat($urandom_range(30), $urandom_range(5),
                                              $urandom_range(3), 1'b0));
        pending_beats.push_back(make_beat(1, 1, 1, 1'b0));
        pending_beats.push_back(make_beat(2, 2, 2, 1'b1));
        send_idle_pct = 0; recv_stall_pct = 0;
        wait_drained();

        // Random phases with varying idle patterns.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 3 ? 21 : 83) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 21 : 83) : 0;
            phase_items = 0;
            while (phase_items < 10) begin
                int n;
                n = $urandom_range(1, 10);
                queue_random_batch(n);
                phase_items += n;
            end
            wait_drained();
        end

        // Back-pressure: hold the receiver while the sender keeps offering.
        send_idle_pct = 0; recv_stall_pct = 0;
        hold_recv = 1'b1;
        queue_random_batch(3);
        queue_random_batch(4);
        queue_random_batch(5);
        repeat (600) @(posedge aclk);
        hold_recv = 1'b0;
        wait_drained();

        // Sender pause until every result of a batch has come, then a final batch.
        queue_random_batch(5);
        while (pending_beats.size() > 0 || s_valid) @(posedge aclk);
        hold_send = 1'b1;
        queue_random_batch(6);
        wait (expected_dispatches.size() == 0);
        hold_send = 1'b0;
        wait_drained();

        repeat (DRAIN_CYC) @(posedge aclk);
        if (error_count == 0 && expected_dispatches.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/mlqs_pkg.sv
rtl/mlqs_front.sv
rtl/mlqs_sched.sv
rtl/multilevel_queue_scheduler_core.sv
tb/multilevel_queue_scheduler_core_test.sv
